FILE: design/rgb_box_blur_3x3_defines.svh
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3 assertion macros
// Shared concurrent assertion forms, clocked on clk, reset by rst.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_3X3_DEFINES_SVH
`define RGB_BOX_BLUR_3X3_DEFINES_SVH

// same-cycle implication, off while in reset
`define RBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define RBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state seen in the cycle after a reset cycle
`define RBB_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and constants shared by the 3x3 box blur modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration registers
  localparam int CFG_W            = 11;
  localparam int CFG_WIDTH_RESET  = 1024;
  localparam int CFG_HEIGHT_RESET = 1024;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  // queue depths and their level widths
  localparam int QDEPTH = 4;
  localparam int QLW    = $clog2(QDEPTH + 1);
  localparam int ODEPTH = 4;
  localparam int OLW    = $clog2(ODEPTH + 1);

  // floor(s / 9) = (s * 7282) >> 16 for s <= 9 * 255
  localparam int SUM_W     = 12;
  localparam int RECIP_W   = 13;
  localparam int DIV_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // where the result pixel sits in the frame
  typedef struct packed {
    logic emit;      // item produces a result
    logic last;      // result is the frame's last pixel
    logic top_ok;    // row above is in frame
    logic bot_ok;    // row below is in frame
    logic left_ok;   // column to the left is in frame
    logic right_ok;  // column to the right is in frame
  } pos_flags_t;

  // one window column plus position info, front to back
  typedef struct packed {
    rgb_t       top;
    rgb_t       mid;
    rgb_t       cur;
    pos_flags_t flags;
  } col_t;

  typedef struct packed {
    rgb_t pix;
    logic last;
  } res_t;

endpackage

`default_nettype wire

FILE: design/rbb_fifo.sv
// ----------------------------------------------------------------------------
// rbb_fifo
// Small register FIFO with fill level; writers hold credit, so no full flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = rbb_pkg::QDEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [LW-1:0] count;
  logic          do_pop;

  assign do_pop = pop && (count != '0);
  assign empty  = (count == '0);
  assign level  = count;
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: design/rbb_front.sv
// ----------------------------------------------------------------------------
// rbb_front
// Takes beats, tracks frame position, runs the line store and emits columns.
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_front #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
  input  logic                              cfg_clear,
  input  logic                              push,
  output logic                              full,
  input  logic                              func,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  input  logic [rbb_pkg::QLW-1:0]           q_level,
  output logic                              q_push,
  output rbb_pkg::col_t                     q_data
);
  import rbb_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int LW = $clog2(MAX_WIDTH + 2);

  typedef struct packed {
    rgb_t upper;
    rgb_t lower;
  } line_t;

  // position counters
  logic [AW-1:0] in_x;
  logic [LW-1:0] lead;
  logic [AW-1:0] cx;
  logic [YW-1:0] cy;

  logic          accept;
  logic [WW-1:0] width_m1;
  logic [HW-1:0] height_m1;
  logic          x_at_end;
  logic          cx_end;
  logic          cy_end;
  pos_flags_t    flags_in;
  rgb_t          pix_in;

  // read stage
  logic          s1_valid;
  logic [AW-1:0] s1_x;
  rgb_t          s1_pix;
  pos_flags_t    s1_flags;
  line_t         mem [MAX_WIDTH];
  line_t         mem_q;
  logic          byp;
  line_t         byp_data;
  line_t         rd;
  line_t         wr_entry;

  assign full   = (QLW'(q_level) + QLW'(s1_valid)) >= QLW'(QDEPTH);
  assign accept = push && !full;

  assign width_m1  = width - 1'b1;
  assign height_m1 = height - 1'b1;
  assign x_at_end  = (WW'(in_x) == width_m1);
  assign cx_end    = (WW'(cx) == width_m1);
  assign cy_end    = (HW'(cy) == height_m1);

  always_comb begin
    flags_in.emit     = (lead == (LW'(width) + LW'(1)));
    flags_in.last     = flags_in.emit && cx_end && cy_end;
    flags_in.top_ok   = (cy != '0);
    flags_in.bot_ok   = !cy_end;
    flags_in.left_ok  = (cx != '0);
    flags_in.right_ok = !cx_end;
  end

  assign pix_in = (func == FUNC_FLUSH) ? '0 : '{red: in_red, green: in_green, blue: in_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      in_x     <= '0;
      lead     <= '0;
      cx       <= '0;
      cy       <= '0;
    end else begin
      s1_valid <= accept;
      if (cfg_clear || (accept && flags_in.last)) begin
        in_x <= '0;
        lead <= '0;
        cx   <= '0;
        cy   <= '0;
      end else if (accept) begin
        in_x <= x_at_end ? '0 : in_x + 1'b1;
        if (!flags_in.emit) begin
          lead <= lead + 1'b1;
        end else if (cx_end) begin
          cx <= '0;
          cy <= cy + 1'b1;
        end else begin
          cx <= cx + 1'b1;
        end
      end
    end
  end

  // entry at x holds the pixels two rows and one row back
  assign rd       = byp ? byp_data : mem_q;
  assign wr_entry = '{upper: rd.lower, lower: s1_pix};

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= in_x;
      s1_pix   <= pix_in;
      s1_flags <= flags_in;
      mem_q    <= mem[in_x];
      byp      <= s1_valid && (in_x == s1_x);  // one-pixel rows hit the same entry
      byp_data <= wr_entry;
    end
    if (s1_valid) begin
      mem[s1_x] <= wr_entry;
    end
  end

  assign q_push = s1_valid;
  always_comb begin
    q_data.top   = rd.upper;
    q_data.mid   = rd.lower;
    q_data.cur   = s1_pix;
    q_data.flags = s1_flags;
  end

endmodule

`default_nettype wire

FILE: design/rbb_back.sv
// ----------------------------------------------------------------------------
// rbb_back
// Shifts the 3x3 window, sums in-frame taps, divides by 9, queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module rbb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_pop,
  input  rbb_pkg::col_t q_data,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          frame_end
);
  import rbb_pkg::*;

  localparam int PW = SUM_W + RECIP_W;

  rgb_t             win [3][3];
  logic             b1_valid;
  pos_flags_t       b1_flags;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;
  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;
  logic             b2_valid;
  logic             b2_last;
  logic [SUM_W-1:0] b2_red;
  logic [SUM_W-1:0] b2_green;
  logic [SUM_W-1:0] b2_blue;
  logic [PW-1:0]    prod_red;
  logic [PW-1:0]    prod_green;
  logic [PW-1:0]    prod_blue;
  res_t             res_in;
  res_t             res_out;
  logic [OLW-1:0]   o_level;

  // keep room in the result queue for everything in flight
  assign q_pop = !q_empty &&
                 ((OLW'(o_level) + OLW'(b1_valid) + OLW'(b2_valid)) < OLW'(ODEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      b1_valid <= q_pop && q_data.flags.emit;
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= q_data.top;
      win[1][2] <= q_data.mid;
      win[2][2] <= q_data.cur;
      b1_flags  <= q_data.flags;
    end
  end

  assign row_ok = {b1_flags.bot_ok, 1'b1, b1_flags.top_ok};
  assign col_ok = {b1_flags.right_ok, 1'b1, b1_flags.left_ok};

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum_red   = sum_red + SUM_W'(win[r][c].red);
          sum_green = sum_green + SUM_W'(win[r][c].green);
          sum_blue  = sum_blue + SUM_W'(win[r][c].blue);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      b2_red   <= sum_red;
      b2_green <= sum_green;
      b2_blue  <= sum_blue;
      b2_last  <= b1_flags.last;
    end
  end

  // divide by 9 through a reciprocal multiply
  assign prod_red   = PW'(b2_red) * PW'(RECIP9);
  assign prod_green = PW'(b2_green) * PW'(RECIP9);
  assign prod_blue  = PW'(b2_blue) * PW'(RECIP9);

  always_comb begin
    res_in.pix.red   = prod_red[DIV_SHIFT +: 8];
    res_in.pix.green = prod_green[DIV_SHIFT +: 8];
    res_in.pix.blue  = prod_blue[DIV_SHIFT +: 8];
    res_in.last      = b2_last;
  end

  rbb_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (ODEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b2_valid),
    .wdata (res_in),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .level (o_level)
  );

  assign out_red   = res_out.pix.red;
  assign out_green = res_out.pix.green;
  assign out_blue  = res_out.pix.blue;
  assign frame_end = res_out.last;

endmodule

`default_nettype wire

FILE: design/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// 3x3 box blur over a raster RGB stream with two line stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue: a beat moves when push is high and full is low. func
//   selects a pixel or a flush beat; a frame is width*height pixels followed
//   by width+1 flush beats. Results form a queue too: the oldest result sits
//   on out_* while empty is low and leaves when pop is high. frame_end marks
//   the frame's last pixel, after which the next frame may start.
//   The first width+1 beats of a frame give no result; after that each beat
//   gives the blurred pixel one row and one pixel behind it.
//   Throughput: one beat per cycle while full is low; the line store is read
//   and written once per beat. A result's data moves through the read stage,
//   column queue, window and sum stages and result queue to out_*.
//   Frame size comes from the APB registers (width at 0x0, height at 0x4),
//   written while idle; any write starts a new frame.
//   When pop stays low the result queue fills, the window stage stops and
//   the column queue fills behind it, after which full rises.
//   Reset (rst, synchronous) empties both queues and the counters and sets
//   the registers to 1024. Line store contents are not cleared: entries not
//   yet written in the current frame never reach a result.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result output
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end
);
  import rbb_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int RST_H = (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  // register file: raw value for readback, clamped value for the datapath
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [CFG_W-1:0] wr_val;
  logic [WW-1:0]    width_clamped;
  logic [HW-1:0]    height_clamped;
  logic             cfg_wr;
  reg_idx_t         reg_idx;

  // column queue between front and back
  logic             cq_push;
  col_t             cq_wdata;
  col_t             cq_rdata;
  logic             cq_pop;
  logic             cq_empty;
  logic [QLW-1:0]   cq_level;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_val  = pwdata[CFG_W-1:0];

  // zero counts as one, oversize counts as the maximum
  always_comb begin
    if (wr_val == '0) begin
      width_clamped  = WW'(1);
      height_clamped = HW'(1);
    end else begin
      width_clamped  = (32'(wr_val) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(wr_val);
      height_clamped = (32'(wr_val) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(CFG_WIDTH_RESET);
      frame_height <= CFG_W'(CFG_HEIGHT_RESET);
      width_eff    <= WW'(RST_W);
      height_eff   <= HW'(RST_H);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH: begin
          frame_width <= wr_val;
          width_eff   <= width_clamped;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= wr_val;
          height_eff   <= height_clamped;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
    endcase
  end

  rbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .width     (width_eff),
    .height    (height_eff),
    .cfg_clear (cfg_wr),
    .push      (push),
    .full      (full),
    .func      (func),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .q_level   (cq_level),
    .q_push    (cq_push),
    .q_data    (cq_wdata)
  );

  rbb_fifo #(
    .W     ($bits(col_t)),
    .DEPTH (QDEPTH)
  ) u_col_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cq_push),
    .wdata (cq_wdata),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .level (cq_level)
  );

  rbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (cq_empty),
    .q_pop     (cq_pop),
    .q_data    (cq_rdata),
    .empty     (empty),
    .pop       (pop),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

FILE: design/rbb_checker.sv
// ----------------------------------------------------------------------------
// rbb_checker
// Port-level checks for rgb_box_blur_3x3, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_box_blur_3x3_defines.svh"

module rbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_end
);

  // both queues come out of reset drained
  `RBB_ASSERT_RESET(a_reset_drained, empty && !full, "queues not drained after reset")

  // a waiting result holds until popped
  `RBB_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(frame_end), "result changed while stalled")

  // the result queue drains only through pops
  `RBB_ASSERT_NOW(a_empty_by_pop, $rose(empty) && !$past(rst), $past(pop), "result lost without pop")

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .frame_end (frame_end)
);

`default_nettype wire

FILE: tb/rgb_box_blur_3x3_test.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_test
// Self-checking bench for the 3x3 RGB box blur. A cycle-free predictor of the
// line stores and window runs next to the block; every popped result is
// compared field by field against the oldest predicted pixel. Frames range
// from 1x1 up to the full line width, with random stalls on both queues.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = MAX_HEIGHT_DEF;
  localparam int BOX_DIV       = 9;     // divisor stays 9 at the frame border
  localparam int MAX_GAP       = 11;    // longest per-beat idle on either side
  localparam int LONG_HOLD     = 300;   // receiver hold-off to fill the block
  localparam int SETTLE_CYCLES = 32;    // quiet time after the last owed result arrives
  localparam int STALL_LIMIT   = 2000;  // watchdog limit on cycles with nothing moving
  localparam int RANDOM_ITEMS  = 1000;
  localparam int PRINT_CAP     = 100;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  logic        func;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        empty;
  logic        pop;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        frame_end;

  rgb_box_blur_3x3 dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .full      (full),
    .func      (func),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .empty     (empty),
    .pop       (pop),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the line stores, window and registers.
  // Line store contents outside the current frame never reach a result, so
  // the block not clearing them at reset does not matter here.
  // --------------------------------------------------------------------------
  rgb_t             row_above  [MAX_W] = '{default: '0};
  rgb_t             row_latest [MAX_W] = '{default: '0};
  rgb_t             win3x3     [9]     = '{default: '0};
  int unsigned      beat_index = 0;          // beats taken in current frame
  logic [CFG_W-1:0] width_reg  = CFG_WIDTH_RESET;
  logic [CFG_W-1:0] height_reg = CFG_HEIGHT_RESET;

  res_t blurred_pending [$];                 // predicted pixels not yet popped

  // bench control and bookkeeping
  int send_gap_max  = MAX_GAP;
  int pop_gap_max   = MAX_GAP;
  int long_hold_req = 0;
  int long_holds    = 0;
  int mismatch_count  = 0;
  int beats_in        = 0;
  int results_checked = 0;
  int reg_accesses    = 0;
  int frames_done     = 0;
  int stall_cycles    = 0;
  int idle_cycles     = 0;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // beats in one whole frame: the pixels plus width+1 drain beats
  function automatic int frame_beats();
    int unsigned w;
    w = clamp_dim(width_reg, MAX_W);
    return w * clamp_dim(height_reg, MAX_H) + w + 1;
  endfunction

  function automatic rgb_t random_rgb();
    rgb_t c;
    c = $urandom();
    return c;
  endfunction

  // Advance the window by one beat; returns 1 with the blurred pixel for the
  // position one row and one pixel behind, once the window has filled.
  function automatic bit window_step(input func_t kind, input rgb_t pixel_in,
                                     output res_t res);
    int unsigned w, h, total, n, col, p, cy, cx, sum_r, sum_g, sum_b;
    int   k, j;
    rgb_t pix, above, middle, tap;
    bit   row_ok, col_ok;
    res   = '0;
    w     = clamp_dim(width_reg, MAX_W);
    h     = clamp_dim(height_reg, MAX_H);
    total = w * h;
    n     = beat_index;
    col   = n % w;
    // a flush beat counts as a black pixel
    pix    = (kind == FUNC_PIXEL) ? pixel_in : '0;
    above  = row_above[col];
    middle = row_latest[col];
    row_above[col]  = middle;
    row_latest[col] = pix;
    for (k = 0; k < 3; k++) begin
      win3x3[k*3]   = win3x3[k*3+1];
      win3x3[k*3+1] = win3x3[k*3+2];
    end
    win3x3[2] = above;
    win3x3[5] = middle;
    win3x3[8] = pix;
    beat_index = n + 1;
    if (n < w + 1) return 1'b0;              // window still filling
    p = n - w - 1;
    if (p >= total) begin
      beat_index = 0;
      return 1'b0;
    end
    cy    = p / w;
    cx    = p % w;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (k = 0; k < 3; k++) begin
      row_ok = (k == 0) ? (cy > 0) : (k == 2) ? (cy + 1 < h) : 1'b1;
      for (j = 0; j < 3; j++) begin
        col_ok = (j == 0) ? (cx > 0) : (j == 2) ? (cx + 1 < w) : 1'b1;
        if (row_ok && col_ok) begin
          tap    = win3x3[k*3+j];
          sum_r += tap.red;
          sum_g += tap.green;
          sum_b += tap.blue;
        end
      end
    end
    res.pix.red   = 8'(sum_r / BOX_DIV);
    res.pix.green = 8'(sum_g / BOX_DIV);
    res.pix.blue  = 8'(sum_b / BOX_DIV);
    res.last      = (p == total - 1);
    if (res.last) begin
      beat_index = 0;
      frames_done++;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard, sampled at the rising edge: checks popped results and register
  // reads, feeds accepted beats and register writes to the predictor, and
  // runs the watchdog on cycles where nothing moves.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    res_t want, got;
    bit   moved;
    if (!rst) begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        results_checked++;
        got.pix  = {out_red, out_green, out_blue};
        got.last = frame_end;
        if (blurred_pending.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: result mismatch, expected none, actual r=%0d g=%0d b=%0d end=%0b",
                     $time, got.pix.red, got.pix.green, got.pix.blue, got.last);
        end else begin
          want = blurred_pending.pop_front();
          check_field("out_red", want.pix.red, got.pix.red);
          check_field("out_green", want.pix.green, got.pix.green);
          check_field("out_blue", want.pix.blue, got.pix.blue);
          check_field("frame_end", want.last, got.last);
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        beats_in++;
        if (window_step(func_t'(func), {in_red, in_green, in_blue}, want))
          blurred_pending.push_back(want);
      end
      if (push && full) stall_cycles++;
      if (psel && penable && pready) begin
        moved = 1'b1;
        reg_accesses++;
        if (pwrite) begin
          // any write starts a new frame, even one that changes nothing
          if (reg_idx_t'(paddr[2]) == REG_FRAME_WIDTH) width_reg = pwdata[CFG_W-1:0];
          else height_reg = pwdata[CFG_W-1:0];
          beat_index = 0;
        end else begin
          check_field("prdata",
                      (reg_idx_t'(paddr[2]) == REG_FRAME_WIDTH) ? width_reg : height_reg,
                      prdata);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles, %0d results still owed",
                 $time, idle_cycles, blurred_pending.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: draws a wait before every pop; a long hold request from a
  // test replaces one draw and is counted out here.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = $urandom_range(pop_gap_max, 0);
      if (long_hold_req > 0) begin
        hold          = long_hold_req;
        long_hold_req = 0;
        long_holds++;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end at a falling edge. push stays
  // high from one beat to the next when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic send_beat(func_t kind, rgb_t px);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push     <= 1'b1;
    func     <= kind;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // stop offering, let every owed result arrive, then let the pipe go quiet
  task automatic settle();
    push <= 1'b0;
    while (blurred_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(bit wr, reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are junk the block must drop
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    logic [31:0] word;
    word           = $urandom();
    word[CFG_W-1:0] = v;
    apb_access(1'b1, idx, word);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    apb_access(1'b0, REG_FRAME_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0);
  endtask

  // One frame at the current size. flush_pct: share of flush beats among the
  // pixels; stop_at >= 0 cuts the frame short; pause_at >= 0 holds the sender
  // at that beat until every owed result has come.
  task automatic send_frame(int flush_pct, int stop_at, int pause_at);
    int    npix, nall, i;
    func_t kind;
    npix = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
    nall = frame_beats();
    for (i = 0; i < nall && (stop_at < 0 || i < stop_at); i++) begin
      if (i == pause_at) begin
        push <= 1'b0;
        @(negedge clk);
        while (blurred_pending.size() != 0) @(negedge clk);
      end
      if (i < npix)
        kind = ($urandom_range(99, 0) < flush_pct) ? FUNC_FLUSH : FUNC_PIXEL;
      else
        kind = $urandom_range(1, 0) ? FUNC_FLUSH : FUNC_PIXEL;  // drain beats
      send_beat(kind, random_rgb());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_reset();
    apb_access(1'b0, REG_FRAME_WIDTH, '0);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0);
  endtask

  task automatic test_directed_frames();
    send_gap_max = MAX_GAP;
    pop_gap_max  = MAX_GAP;
    // saturated 3x2 frame: corners and edges show the fixed divisor
    set_frame(3, 2);
    repeat (6) send_beat(FUNC_PIXEL, rgb_t'(24'hFFFFFF));
    repeat (4) send_beat(FUNC_FLUSH, random_rgb());
    // 4x2 with bit patterns, a flush inside the pixels, and pixel beats in
    // the drain that must be ignored
    set_frame(4, 2);
    send_beat(FUNC_PIXEL, rgb_t'(24'h000000));
    send_beat(FUNC_PIXEL, rgb_t'(24'hFFFFFF));
    send_beat(FUNC_PIXEL, rgb_t'(24'h55AA0F));
    send_beat(FUNC_FLUSH, rgb_t'(24'hFFFFFF));
    send_beat(FUNC_PIXEL, rgb_t'(24'hAA55F0));
    send_beat(FUNC_PIXEL, rgb_t'(24'hFF0000));
    send_beat(FUNC_PIXEL, rgb_t'(24'h00FF00));
    send_beat(FUNC_PIXEL, rgb_t'(24'h0000FF));
    send_beat(FUNC_FLUSH, random_rgb());
    send_beat(FUNC_PIXEL, rgb_t'(24'hFFFFFF));
    send_beat(FUNC_FLUSH, random_rgb());
    send_beat(FUNC_PIXEL, random_rgb());
    send_beat(FUNC_FLUSH, random_rgb());
  endtask

  task automatic test_dimension_extremes();
    send_gap_max = MAX_GAP;
    pop_gap_max  = MAX_GAP;
    set_frame(1, 1);
    send_frame(0, -1, -1);
    set_frame(0, 0);           // both clamp up to 1
    send_frame(5, -1, -1);
    set_frame(0, 5);
    send_frame(5, -1, -1);
    set_frame(6, 0);
    send_frame(5, -1, -1);
    // full-width frames: short gaps to keep the run bounded
    send_gap_max = 2;
    pop_gap_max  = 2;
    set_frame(1024, 1);
    send_frame(2, -1, -1);
    set_frame(2047, 2);        // width clamps to 1024
    send_frame(2, -1, -1);
    set_frame(1, 2047);        // height clamps to 1024
    send_frame(2, -1, -1);
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender streams: queues fill, full rises
    set_frame(8, 4);
    send_gap_max  = 0;
    pop_gap_max   = 0;
    long_hold_req = LONG_HOLD;
    send_frame(5, -1, -1);
    // next frame back to back, sender waits mid-frame for the block to drain
    send_gap_max = MAX_GAP;
    pop_gap_max  = MAX_GAP;
    send_frame(5, -1, 20);
  endtask

  task automatic test_random_frames();
    int               goal, stop_at, choice;
    bit               need_cfg;
    logic [CFG_W-1:0] w, h;
    goal     = beats_in + RANDOM_ITEMS;
    need_cfg = 1'b1;
    while (beats_in < goal) begin
      if (need_cfg || $urandom_range(9, 0) < 6) begin
        settle();
        if (need_cfg && $urandom_range(1, 0) && width_reg <= 48) begin
          // same-value write after a cut frame: must restart the frame
          write_reg(REG_FRAME_WIDTH, width_reg);
        end else begin
          w = ($urandom_range(99, 0) < 85) ? $urandom_range(12, 1) : $urandom_range(48, 13);
          h = $urandom_range(8, 1);
          if ($urandom_range(19, 0) == 0) w = 0;
          if ($urandom_range(19, 0) == 0) h = 0;
          choice = $urandom_range(3, 0);
          if (choice != 1 || width_reg > 48) write_reg(REG_FRAME_WIDTH, w);
          if (choice != 0 || height_reg > 8) write_reg(REG_FRAME_HEIGHT, h);
        end
        if ($urandom_range(3, 0) == 0) apb_access(1'b0, REG_FRAME_HEIGHT, '0);
      end
      // idle-free stretches now and then on each side
      send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
      pop_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
      stop_at = ($urandom_range(99, 0) < 15) ? $urandom_range(frame_beats() - 1, 0) : -1;
      send_frame(($urandom_range(9, 0) == 0) ? 50 : 5, stop_at, -1);
      need_cfg = (stop_at >= 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk     = 1'b0;
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    push    = 1'b0;
    func    = FUNC_PIXEL;
    in_red  = '0;
    in_green = '0;
    in_blue = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_reset();
    test_directed_frames();
    test_dimension_extremes();
    test_backpressure();
    test_random_frames();
    settle();

    $display("Sent %0d beats over %0d complete frames and %0d register accesses.",
             beats_in, frames_done, reg_accesses);
    $display("Checked %0d results; input held off %0d cycles, %0d long result holds.",
             results_checked, stall_cycles, long_holds);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
